FILE: rtl/vft_pkg.sv
// Package for the virtual FAT16 table generator.
// Holds sizing constants, FAT codes and the command type passed front to back.
// No dependencies.
package vft_pkg;

  localparam int MAX_FILES     = 16;
  localparam int CLUSTER_BYTES = 4096;

  localparam int OP_W      = 1;
  localparam int SLOT_W    = 4;
  localparam int LEN_W     = 24;
  localparam int IDX_W     = 16;
  localparam int VAL_W     = 16;

  // Slot address width inside the count store
  localparam int SADDR_W   = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int CB_SHIFT  = $clog2(CLUSTER_BYTES);
  localparam int MAX_CNT   = ((1 << LEN_W) - 1 + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
  localparam int CNT_W     = $clog2(MAX_CNT + 1);
  localparam int FIRST_CL  = 2;
  // Running cluster number never exceeds first cluster plus all counts
  localparam int CL_W      = $clog2(MAX_FILES * MAX_CNT + FIRST_CL + 1);

  localparam logic [OP_W-1:0]  OP_LOAD = 1'b0;
  localparam logic [OP_W-1:0]  OP_READ = 1'b1;

  localparam logic [7:0]       FAT_MEDIA = 8'hF8;
  localparam logic [VAL_W-1:0] FAT_EOC   = {8'hFF, FAT_MEDIA};
  localparam logic [VAL_W-1:0] FAT_CLEAN = 16'h8000 | 16'h4000;
  localparam logic [VAL_W-1:0] FAT_BAD   = 16'hFFF7;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_READ,
    CMD_EOC,
    CMD_CLEAN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [SADDR_W-1:0] slot;
    logic               slot_ok;
    logic [CNT_W-1:0]   count;
    logic [IDX_W-1:0]   idx;
  } cmd_t;

endpackage

FILE: rtl/vft_front.sv
// Front end of the FAT16 table generator: accepts items, classifies them and
// queues them for the back end in a two-entry command queue.
// Depends on vft_pkg.
module vft_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [vft_pkg::OP_W-1:0]   operation_i,
  input  logic [vft_pkg::SLOT_W-1:0] slot_i,
  input  logic [vft_pkg::LEN_W-1:0]  file_length_i,
  input  logic [vft_pkg::IDX_W-1:0]  entry_index_i,
  output logic                       cmd_valid_o,
  output vft_pkg::cmd_t              cmd_o,
  input  logic                       cmd_pop_i
);

  vft_pkg::cmd_t              cmd_in;
  vft_pkg::cmd_t              mem_q [2];
  logic                       wr_q, wr_d, rd_q, rd_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic                       do_push, do_pop;
  logic [vft_pkg::LEN_W:0]    len_up;

  // Round the length up to whole clusters
  assign len_up = {1'b0, file_length_i} + (vft_pkg::LEN_W+1)'(vft_pkg::CLUSTER_BYTES - 1);

  // Classify the incoming item
  always_comb begin
    cmd_in.slot    = vft_pkg::SADDR_W'(slot_i);
    cmd_in.slot_ok = (int'(slot_i) < vft_pkg::MAX_FILES);
    cmd_in.count   = vft_pkg::CNT_W'(len_up >> vft_pkg::CB_SHIFT);
    cmd_in.idx     = entry_index_i;
    if (operation_i == vft_pkg::OP_LOAD) begin
      cmd_in.kind = vft_pkg::CMD_LOAD;
    end else if (entry_index_i == vft_pkg::IDX_W'(0)) begin
      cmd_in.kind = vft_pkg::CMD_EOC;
    end else if (entry_index_i == vft_pkg::IDX_W'(1)) begin
      cmd_in.kind = vft_pkg::CMD_CLEAN;
    end else begin
      cmd_in.kind = vft_pkg::CMD_READ;
    end
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Advance queue pointers and fill count
  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the classified command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_in;
    end
  end

endmodule

FILE: rtl/vft_back.sv
// Back end of the FAT16 table generator: applies loads to the count store,
// walks the file slots for reads and buffers results in a two-entry queue.
// Depends on vft_pkg.
module vft_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cmd_valid_i,
  input  vft_pkg::cmd_t             cmd_i,
  output logic                      cmd_pop_o,
  output logic                      empty,
  input  logic                      pop,
  output logic [vft_pkg::VAL_W-1:0] entry_value_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [vft_pkg::CNT_W-1:0]    counts_q [vft_pkg::MAX_FILES];
  logic [vft_pkg::SADDR_W-1:0]  slot_q, slot_d;
  logic [vft_pkg::CL_W-1:0]     cluster_q, cluster_d;
  logic [vft_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [vft_pkg::VAL_W-1:0]    res_q, res_d;

  logic [vft_pkg::CNT_W-1:0]    cnt;
  logic [vft_pkg::CL_W-1:0]     cl_end, idx_ext;
  logic                         hit, is_last, last_slot, load_we;

  logic [vft_pkg::VAL_W-1:0]    out_mem_q [2];
  logic                         out_wr_q, out_rd_q;
  logic [1:0]                   out_cnt_q;
  logic                         out_full, out_push, out_pop;

  // Test the current slot's cluster range
  assign cnt       = counts_q[slot_q];
  assign cl_end    = cluster_q + vft_pkg::CL_W'(cnt);
  assign idx_ext   = vft_pkg::CL_W'(idx_q);
  assign hit       = (cnt != '0) && (idx_ext >= cluster_q) && (idx_ext < cl_end);
  assign is_last   = (idx_ext == cl_end - vft_pkg::CL_W'(1));
  assign last_slot = (slot_q == vft_pkg::SADDR_W'(vft_pkg::MAX_FILES - 1));

  assign out_full  = (out_cnt_q == 2'd2);
  assign out_push  = (state_q == ST_EMIT) && !out_full;
  assign out_pop   = pop && !empty;
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign load_we   = cmd_pop_o && (cmd_i.kind == vft_pkg::CMD_LOAD) && cmd_i.slot_ok;

  // Sequence one command at a time
  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    cluster_d = cluster_q;
    idx_d     = idx_q;
    res_d     = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            vft_pkg::CMD_LOAD: state_d = ST_IDLE;
            vft_pkg::CMD_EOC: begin
              res_d   = vft_pkg::FAT_EOC;
              state_d = ST_EMIT;
            end
            vft_pkg::CMD_CLEAN: begin
              res_d   = vft_pkg::FAT_CLEAN;
              state_d = ST_EMIT;
            end
            vft_pkg::CMD_READ: begin
              idx_d     = cmd_i.idx;
              slot_d    = '0;
              cluster_d = vft_pkg::CL_W'(vft_pkg::FIRST_CL);
              state_d   = ST_WALK;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        cluster_d = cl_end;
        slot_d    = slot_q + vft_pkg::SADDR_W'(1);
        priority if (hit) begin
          res_d   = is_last ? vft_pkg::FAT_EOC : idx_q + vft_pkg::IDX_W'(1);
          state_d = ST_EMIT;
        end else if (last_slot) begin
          res_d   = vft_pkg::FAT_BAD;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_WALK;
        end
      end
      ST_EMIT: begin
        if (!out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int i = 0; i < vft_pkg::MAX_FILES; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (load_we) begin
        counts_q[cmd_i.slot] <= cmd_i.count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q    <= slot_d;
    cluster_q <= cluster_d;
    idx_q     <= idx_d;
    res_q     <= res_d;
  end

  // Hold finished results until the receiver takes them
  assign empty         = (out_cnt_q == 2'd0);
  assign entry_value_o = out_mem_q[out_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      if (out_push) begin
        out_wr_q <= ~out_wr_q;
      end
      if (out_pop) begin
        out_rd_q <= ~out_rd_q;
      end
      out_cnt_q <= out_cnt_q + 2'(out_push) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_mem_q[out_wr_q] <= res_q;
    end
  end

endmodule

FILE: rtl/virtual_fat16_table_generator.sv
// Top level of the virtual FAT16 table generator.
// Instantiates vft_front and vft_back; depends on vft_pkg.
//
// Usage: items enter through a queue-style port (push/full) and are taken
// at an edge with push high and full low. A load (operation 0) stores the
// cluster count of a file length in a slot and gives no result. A read
// (operation 1) gives one 16-bit FAT entry on entry_value_o, shown while
// empty is low and taken at an edge with pop high and empty low.
// Entries 0 and 1 pass through the command queue, the back end's result
// register and the output queue before empty goes low; other reads walk the
// file slots one per cycle from slot 0 in the back end up to the slot that
// holds the cluster; a bad entry comes after all 16 (MAX_FILES) slots are walked.
// The back end takes one command at a time: it applies a load as it takes
// it and holds any other command until its result enters the output queue.
// A two-entry command queue lets the front keep accepting during a walk.
// Reset clears all slot counts at once (no files) and empties both queues.
// When the receiver stalls, results fill a two-entry output queue, the back
// end holds its finished result, and full rises once the command queue is
// also full; nothing is dropped.
module virtual_fat16_table_generator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [vft_pkg::OP_W-1:0]   operation_i,
  input  logic [vft_pkg::SLOT_W-1:0] slot_i,
  input  logic [vft_pkg::LEN_W-1:0]  file_length_i,
  input  logic [vft_pkg::IDX_W-1:0]  entry_index_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [vft_pkg::VAL_W-1:0]  entry_value_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  vft_pkg::cmd_t cmd;

  vft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .operation_i  (operation_i),
    .slot_i       (slot_i),
    .file_length_i(file_length_i),
    .entry_index_i(entry_index_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  vft_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .cmd_pop_o    (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .entry_value_o(entry_value_o)
  );

  // An accepted item is waiting in the command queue in the next cycle
  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> cmd_valid)
    else $error("accepted item missing from command queue");

  // Back end takes commands only when one is present
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  // A command left waiting does not change
  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && !cmd_pop |=> cmd_valid && $stable(cmd))
    else $error("waiting command changed");

endmodule
